/* hdl/sm64b_pkg.sv */
// sm64b_pkg: constants, mode codes, fsm states and controller/datapath structs
// for the splitmix64 bounded generator; no dependencies
`default_nettype none
package sm64b_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  localparam int unsigned SHIFT_PRE  = 30;
  localparam int unsigned SHIFT_MID  = 27;
  localparam int unsigned SHIFT_POST = 31;
  localparam int unsigned FRAC_SHIFT = 11;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned BOUND_W   = 63;
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_RAW     = 2'd0,
    MODE_FRAC    = 2'd1,
    MODE_BOUNDED = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_THRESH,
    ST_ADVANCE,
    ST_MIX_A,
    ST_MIX_B,
    ST_CHECK,
    ST_MODULO,
    ST_OUTPUT
  } ctrl_state_t;

  typedef struct packed {
    logic       take_in;
    logic       adv;
    logic       mul_en;
    logic       mul_sel;
    logic [1:0] mul_step;
    logic       div_start;
    logic       div_src;
    logic       cap_thr;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bound_zero;
    logic       div_done;
    logic       reject;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hdl/sm64b_div.sv */
// sm64b_div: restoring remainder unit, one quotient bit per cycle
// uses sm64b_pkg for widths and step count
`default_nettype none
module sm64b_div import sm64b_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [WORD_W-1:0]    dividend,
  input  wire logic [BOUND_W-1:0]   divisor,
  output logic                      done,
  output logic [BOUND_W-1:0]        rem
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0]    quo_r, quo_nxt;
  logic [BOUND_W-1:0]   rem_r, rem_nxt;
  logic [WORD_W-1:0]    trial;
  logic [WORD_W-1:0]    diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[WORD_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      rem_nxt = ge ? diff[BOUND_W-1:0] : trial[BOUND_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

/* hdl/sm64b_dp.sv */
// sm64b_dp: generator state, mixer with split 32x32 multiplier, threshold,
// remainder unit and result register; uses sm64b_pkg and sm64b_div
`default_nettype none
module sm64b_dp import sm64b_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [WORD_W-1:0]  cfg_wdata,
  input  wire logic [1:0]         in_mode,
  input  wire logic [BOUND_W-1:0] in_bound,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  output logic [WORD_W-1:0]       res_value,
  output logic                    res_status
);

  logic [WORD_W-1:0]  state_r;
  logic [WORD_W-1:0]  z_r;
  logic [WORD_W-1:0]  acc_r;
  logic [WORD_W-1:0]  prod_r;
  logic [1:0]         mode_r;
  logic [BOUND_W-1:0] bound_r;
  logic [BOUND_W-1:0] thresh_r;
  logic [WORD_W-1:0]  value_r, value_nxt;
  logic               status_r, status_nxt;

  logic [WORD_W-1:0]  adv_sum;
  logic [WORD_W-1:0]  mul_k;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [WORD_W-1:0]  mul_p;
  logic [WORD_W-1:0]  acc_sum;
  logic [WORD_W-1:0]  mix_next;
  logic [WORD_W-1:0]  div_dividend;
  logic               div_done;
  logic [BOUND_W-1:0] div_rem;
  logic               bound_zero;

  assign adv_sum = state_r + GOLDEN_STEP;

  // low 64 bits of z * k from three 32x32 partial products
  assign mul_k   = cmd.mul_sel ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a   = (cmd.mul_step == 2'd2) ? z_r[63:32] : z_r[31:0];
  assign mul_b   = (cmd.mul_step == 2'd1) ? mul_k[63:32] : mul_k[31:0];
  assign mul_p   = WORD_W'(mul_a) * WORD_W'(mul_b);
  assign acc_sum = acc_r + {prod_r[31:0], 32'd0};
  assign mix_next = cmd.mul_sel ? (acc_sum ^ (acc_sum >> SHIFT_POST))
                                : (acc_sum ^ (acc_sum >> SHIFT_MID));

  assign bound_zero   = (bound_r == '0);
  assign div_dividend = cmd.div_src ? z_r : (WORD_W'(0) - {1'b0, bound_r});

  sm64b_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (bound_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    value_nxt  = '0;
    status_nxt = 1'b0;
    unique case (mode_r)
      MODE_RAW:  value_nxt = z_r;
      MODE_FRAC: value_nxt = z_r >> FRAC_SHIFT;
      MODE_BOUNDED: begin
        if (bound_zero) begin
          status_nxt = 1'b1;
        end else begin
          value_nxt = {1'b0, div_rem};
        end
      end
      default: value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GOLDEN_STEP;
    end else if (cfg_we) begin
      state_r <= (cfg_wdata == '0) ? GOLDEN_STEP : cfg_wdata;
    end else if (cmd.adv) begin
      state_r <= adv_sum;
    end

    if (cmd.take_in) begin
      mode_r  <= in_mode;
      bound_r <= in_bound;
    end
    if (cmd.cap_thr) begin
      thresh_r <= div_rem;
    end
    if (cmd.adv) begin
      z_r <= adv_sum ^ (adv_sum >> SHIFT_PRE);
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p;
      unique case (cmd.mul_step)
        2'd0: acc_r <= acc_r;
        2'd1: acc_r <= prod_r;
        2'd2: acc_r <= acc_sum;
        2'd3: z_r   <= mix_next;
      endcase
    end
    if (cmd.load_out) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign stat.mode       = mode_r;
  assign stat.bound_zero = bound_zero;
  assign stat.div_done   = div_done;
  assign stat.reject     = z_r < {1'b0, thresh_r};

  assign res_value  = value_r;
  assign res_status = status_r;

endmodule
`default_nettype wire

/* hdl/sm64b_ctrl.sv */
// sm64b_ctrl: sequencing state machine and output valid flag
// uses sm64b_pkg for states, mode codes and command/status structs
`default_nettype none
module sm64b_ctrl import sm64b_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.mode == MODE_RAW || stat.mode == MODE_FRAC) begin
          state_nxt = ST_ADVANCE;
        end else if (stat.mode == MODE_BOUNDED && !stat.bound_zero) begin
          state_nxt = ST_THRESH;
        end else begin
          state_nxt = ST_OUTPUT;
        end
      end
      ST_THRESH: begin
        if (stat.div_done) begin
          state_nxt = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        cnt_nxt   = '0;
        state_nxt = ST_MIX_A;
      end
      ST_MIX_A: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_MIX_B;
        end
      end
      ST_MIX_B: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.mode != MODE_BOUNDED) begin
          state_nxt = ST_OUTPUT;
        end else if (stat.reject) begin
          state_nxt = ST_ADVANCE;
        end else begin
          state_nxt = ST_MODULO;
        end
      end
      ST_MODULO: begin
        if (stat.div_done) begin
          state_nxt = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.take_in = in_tvalid;
      end
      ST_DECODE: begin
        cmd.div_start = (stat.mode == MODE_BOUNDED) && !stat.bound_zero;
      end
      ST_THRESH: cmd.cap_thr = stat.div_done;
      ST_ADVANCE: cmd.adv = 1'b1;
      ST_MIX_A: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = cnt_r;
      end
      ST_MIX_B: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = 1'b1;
        cmd.mul_step = cnt_r;
      end
      ST_CHECK: begin
        cmd.div_src   = 1'b1;
        cmd.div_start = (stat.mode == MODE_BOUNDED) && !stat.reject;
      end
      ST_MODULO: cmd.div_src = 1'b1;
      ST_OUTPUT: cmd.load_out = slot_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

/* hdl/splitmix64_bounded_rng.sv */
// splitmix64_bounded_rng: top level, controller plus datapath
// uses sm64b_pkg, sm64b_ctrl, sm64b_dp (which holds sm64b_div)
//
//   channel   direction  handshake            payload
//   in_       slave      in_tvalid/in_tready  tdata bound, tuser mode
//   out_      master     out_tvalid/tready    tdata value, tuser status
//   cfg_      write      cfg_we               cfg_wdata seed
//
// one item at a time: raw and fraction modes do one state advance and two 64-bit
// multiplies, each from three 32x32 partial products; bounded mode adds two passes
// of the bit-serial remainder unit (threshold, modulo) and redoes the advance and
// multiplies for each rejected draw; zero bound and mode 3 go straight to output.
// reset loads the golden constant as state; a result waits in the output
// register while the next item runs, which stalls there until it is taken.
`default_nettype none
module splitmix64_bounded_rng import sm64b_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [WORD_W-1:0]  cfg_wdata,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [WORD_W-1:0]  in_tdata,   // [62:0] bound, [63] unused
  input  wire logic [1:0]         in_tuser,   // [1:0] mode
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [WORD_W-1:0]       out_tdata,  // [63:0] value
  output logic [0:0]              out_tuser   // [0] status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     res_status;

  sm64b_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sm64b_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_tuser),
    .in_bound   (in_tdata[BOUND_W-1:0]),
    .cmd        (cmd),
    .stat       (stat),
    .res_value  (out_tdata),
    .res_status (res_status)
  );

  assign out_tuser = res_status;

`ifndef SYNTH
  // error status always carries a zero value
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("error status with nonzero value");

  // after a transfer in, the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // remainder unit done is a single-cycle pulse
  a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |=> !stat.div_done)
    else $error("divider done held");

  // a result is loaded only into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_tvalid || out_tready)
    else $error("result overwritten");
`endif

endmodule
`default_nettype wire
